/* sv/dqc_pkg.sv */
package dqc_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int FILL_W   = 5;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(CAPACITY);

  typedef struct packed {
    logic                     shift_right;
    logic                     shift_left;
    logic                     write_tail;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] push_value;
  } cell_ctrl_t;

endpackage

/* sv/double_ended_queue_core.sv */
// Bounded double-ended queue of signed 32-bit values, up to 16 entries.
// The input channel (in_valid, in_ready) carries one operation per beat:
// push back, push front, pop back or pop front, with push_value used by
// pushes only. The output channel (out_valid, out_ready) returns one beat
// per operation with out_value, status and fill_count after the operation.
// Entries sit in a row of cells with the front in the first cell; a push at
// the front or a pop at the front shifts the whole row by one cell, and the
// back is written or read at the cell picked by the fill count.
// Every operation finishes in the cycle it is accepted, and its result is
// held in the output register from the next cycle; throughput is one
// operation per cycle while out_ready stays high.
// When the receiver stalls, the result waits in the output register and
// in_ready drops until that beat is taken.
// A pop from an empty queue reports an error with value 0, and a push to a
// full queue reports an error and drops the value; neither changes state.
// Reset empties the queue and drops out_valid.
module double_ended_queue_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dqc_pkg::OP_W-1:0]            operation,
  input  logic signed [dqc_pkg::DATA_W-1:0]   push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dqc_pkg::DATA_W-1:0]   out_value,
  output logic [dqc_pkg::STAT_W-1:0]          status,
  output logic [dqc_pkg::FILL_W-1:0]          fill_count
);

  logic [dqc_pkg::CNT_W-1:0]             count;
  logic [dqc_pkg::CNT_W-1:0]             count_next;
  logic                                  accept;
  logic                                  is_full;
  logic                                  is_empty;
  logic signed [dqc_pkg::DATA_W-1:0]     result_value;
  logic [dqc_pkg::STAT_W-1:0]            result_status;
  dqc_pkg::cell_ctrl_t                   ctrl;
  logic signed [dqc_pkg::DATA_W-1:0]     cell_data [dqc_pkg::CAPACITY];
  logic signed [dqc_pkg::DATA_W-1:0]     tap [dqc_pkg::CAPACITY+1];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = count == dqc_pkg::COUNT_FULL;
  assign is_empty = count == '0;

  always_comb begin
    ctrl.shift_right = 1'b0;
    ctrl.shift_left  = 1'b0;
    ctrl.write_tail  = 1'b0;
    ctrl.count       = count;
    ctrl.push_value  = push_value;
    count_next       = count;
    result_value     = '0;
    result_status    = dqc_pkg::ST_OK;
    case (operation)
      dqc_pkg::OP_PUSH_BACK, dqc_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          result_status = dqc_pkg::ST_FULL;
        end else begin
          ctrl.write_tail  = accept && (operation == dqc_pkg::OP_PUSH_BACK);
          ctrl.shift_right = accept && (operation == dqc_pkg::OP_PUSH_FRONT);
          count_next       = count + dqc_pkg::CNT_W'(1);
          result_value     = push_value;
        end
      end
      dqc_pkg::OP_POP_BACK: begin
        if (is_empty) begin
          result_status = dqc_pkg::ST_EMPTY;
        end else begin
          count_next   = count - dqc_pkg::CNT_W'(1);
          result_value = tap[dqc_pkg::CAPACITY];
        end
      end
      default: begin
        if (is_empty) begin
          result_status = dqc_pkg::ST_EMPTY;
        end else begin
          ctrl.shift_left = accept;
          count_next      = count - dqc_pkg::CNT_W'(1);
          result_value    = cell_data[0];
        end
      end
    endcase
  end

  assign tap[0] = '0;

  for (genvar i = 0; i < dqc_pkg::CAPACITY; i++) begin : g_cell
    logic signed [dqc_pkg::DATA_W-1:0] left_data;
    logic signed [dqc_pkg::DATA_W-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_data = push_value;
    end else begin : g_body
      assign left_data = cell_data[i-1];
    end

    if (i == dqc_pkg::CAPACITY - 1) begin : g_end
      assign right_data = '0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    dqc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .position   (dqc_pkg::IDX_W'(i)),
      .from_left  (left_data),
      .from_right (right_data),
      .tap_in     (tap[i]),
      .data       (cell_data[i]),
      .tap_out    (tap[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value  <= result_value;
      status     <= result_status;
      fill_count <= dqc_pkg::FILL_W'(count_next);
    end
  end

endmodule

/* sv/dqc_cell.sv */
module dqc_cell (
  input  logic                                      clk,
  input  dqc_pkg::cell_ctrl_t                       ctrl,
  input  logic [dqc_pkg::IDX_W-1:0]                 position,
  input  logic signed [dqc_pkg::DATA_W-1:0]         from_left,
  input  logic signed [dqc_pkg::DATA_W-1:0]         from_right,
  input  logic signed [dqc_pkg::DATA_W-1:0]         tap_in,
  output logic signed [dqc_pkg::DATA_W-1:0]         data,
  output logic signed [dqc_pkg::DATA_W-1:0]         tap_out
);

  logic is_tail;
  logic is_last;

  assign is_tail = ctrl.count == dqc_pkg::CNT_W'(position);
  assign is_last = ctrl.count == (dqc_pkg::CNT_W'(position) + dqc_pkg::CNT_W'(1));

  // The last occupied cell drives its value onto the tap line for a pop at the back.
  assign tap_out = is_last ? (tap_in | data) : tap_in;

  always_ff @(posedge clk) begin
    if (ctrl.shift_right) begin
      data <= from_left;
    end else if (ctrl.shift_left) begin
      data <= from_right;
    end else if (ctrl.write_tail && is_tail) begin
      data <= ctrl.push_value;
    end
  end

endmodule

/* sv/dqc_checker.sv */
module dqc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [dqc_pkg::DATA_W-1:0]   out_value,
  input logic [dqc_pkg::STAT_W-1:0]          status,
  input logic [dqc_pkg::FILL_W-1:0]          fill_count
);

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_count <= dqc_pkg::FILL_W'(dqc_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_error_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dqc_pkg::ST_OK |-> out_value == '0)
    else $error("error beat carries a nonzero value");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dqc_pkg::ST_EMPTY |-> fill_count == '0)
    else $error("empty error with nonzero fill count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dqc_pkg::ST_FULL
      |-> fill_count == dqc_pkg::FILL_W'(dqc_pkg::CAPACITY))
    else $error("full error below capacity");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

bind double_ended_queue_core dqc_checker u_dqc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_value  (out_value),
  .status     (status),
  .fill_count (fill_count)
);

/* dv/tb.sv */
module tb;

  localparam int RANDOM_OPS    = 850;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DIRECTED_ROWS = 7 + dqc_pkg::CAPACITY + 2;
  localparam int ROW_W         = $clog2(DIRECTED_ROWS + 1);
  localparam int LOG_W         = 6;
  localparam int LOG_DEPTH     = 1 << LOG_W;

  typedef struct packed {
    logic signed [dqc_pkg::DATA_W-1:0] value;
    logic [dqc_pkg::STAT_W-1:0]        stat;
    logic [dqc_pkg::FILL_W-1:0]        fill;
  } deque_result_t;

  typedef struct packed {
    logic [dqc_pkg::OP_W-1:0]          op;
    logic signed [dqc_pkg::DATA_W-1:0] val;
    logic                              typed;
    deque_result_t                     want;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [dqc_pkg::OP_W-1:0]          operation = dqc_pkg::OP_PUSH_BACK;
  logic signed [dqc_pkg::DATA_W-1:0] push_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [dqc_pkg::DATA_W-1:0] out_value;
  logic [dqc_pkg::STAT_W-1:0]        status;
  logic [dqc_pkg::FILL_W-1:0]        fill_count;

  logic signed [dqc_pkg::DATA_W-1:0] shadow_store [dqc_pkg::CAPACITY];
  logic [dqc_pkg::IDX_W-1:0]         shadow_front = '0;
  logic [dqc_pkg::CNT_W-1:0]         shadow_count = '0;

  deque_result_t     result_log [LOG_DEPTH];
  logic [LOG_W-1:0]  log_wr_ptr = '0;
  logic [LOG_W-1:0]  log_rd_ptr = '0;
  stim_row_t         directed_rows [DIRECTED_ROWS];
  logic [ROW_W-1:0]  row_fill = '0;
  int                failures = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 33;
  int                recv_idle_pct = 46;

  double_ended_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .push_value(push_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .status    (status),
    .fill_count(fill_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic deque_result_t deque_apply(
      input logic [dqc_pkg::OP_W-1:0] op,
      input logic signed [dqc_pkg::DATA_W-1:0] val);
    deque_result_t             res;
    logic [dqc_pkg::IDX_W-1:0] slot;
    res.value = '0;
    res.stat  = dqc_pkg::ST_OK;
    if (op == dqc_pkg::OP_PUSH_BACK || op == dqc_pkg::OP_PUSH_FRONT) begin
      if (int'(shadow_count) >= dqc_pkg::CAPACITY) begin
        res.stat = dqc_pkg::ST_FULL;
      end else begin
        if (op == dqc_pkg::OP_PUSH_BACK) begin
          slot = dqc_pkg::IDX_W'((int'(shadow_front) + int'(shadow_count))
                                 % dqc_pkg::CAPACITY);
        end else begin
          shadow_front = dqc_pkg::IDX_W'((int'(shadow_front) + dqc_pkg::CAPACITY - 1)
                                         % dqc_pkg::CAPACITY);
          slot = shadow_front;
        end
        shadow_store[slot] = val;
        shadow_count = shadow_count + dqc_pkg::CNT_W'(1);
        res.value = val;
      end
    end else if (shadow_count == '0) begin
      res.stat = dqc_pkg::ST_EMPTY;
    end else begin
      if (op == dqc_pkg::OP_POP_BACK) begin
        slot = dqc_pkg::IDX_W'((int'(shadow_front) + int'(shadow_count) - 1)
                               % dqc_pkg::CAPACITY);
      end else begin
        slot = shadow_front;
        shadow_front = dqc_pkg::IDX_W'((int'(shadow_front) + 1) % dqc_pkg::CAPACITY);
      end
      res.value = shadow_store[slot];
      shadow_count = shadow_count - dqc_pkg::CNT_W'(1);
    end
    res.fill = dqc_pkg::FILL_W'(shadow_count);
    return res;
  endfunction

  function automatic stim_row_t make_row(input logic [dqc_pkg::OP_W-1:0] op,
                                         input logic signed [dqc_pkg::DATA_W-1:0] val,
                                         input logic typed,
                                         input logic signed [dqc_pkg::DATA_W-1:0] v,
                                         input logic [dqc_pkg::STAT_W-1:0] s,
                                         input int f);
    stim_row_t r;
    r.op         = op;
    r.val        = val;
    r.typed      = typed;
    r.want.value = v;
    r.want.stat  = s;
    r.want.fill  = dqc_pkg::FILL_W'(f);
    return r;
  endfunction

  task automatic add_row(input stim_row_t r);
    directed_rows[row_fill] = r;
    row_fill = row_fill + ROW_W'(1);
  endtask

  function automatic logic signed [dqc_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_op(input logic [dqc_pkg::OP_W-1:0] op,
                          input logic signed [dqc_pkg::DATA_W-1:0] val,
                          input logic typed, input deque_result_t want);
    deque_result_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    push_value <= val;
    do @(posedge clk); while (!in_ready);
    predicted = deque_apply(op, val);
    result_log[log_wr_ptr] = typed ? want : predicted;
    log_wr_ptr = log_wr_ptr + LOG_W'(1);
  endtask

  initial begin
    int                       push_bias;
    int                       burst_left;
    logic [dqc_pkg::OP_W-1:0] op;
    add_row(make_row(dqc_pkg::OP_POP_BACK,   32'sd0, 1'b1, 32'sd0, dqc_pkg::ST_EMPTY, 0));
    add_row(make_row(dqc_pkg::OP_POP_FRONT,  32'sd0, 1'b1, 32'sd0, dqc_pkg::ST_EMPTY, 0));
    add_row(make_row(dqc_pkg::OP_PUSH_BACK,  32'sh7fffffff, 1'b1,
                     32'sh7fffffff, dqc_pkg::ST_OK, 1));
    add_row(make_row(dqc_pkg::OP_PUSH_FRONT, 32'sh80000000, 1'b1,
                     32'sh80000000, dqc_pkg::ST_OK, 2));
    add_row(make_row(dqc_pkg::OP_POP_FRONT,  32'sd0, 1'b1, 32'sh80000000,
                     dqc_pkg::ST_OK, 1));
    add_row(make_row(dqc_pkg::OP_POP_BACK,   32'sd0, 1'b1, 32'sh7fffffff,
                     dqc_pkg::ST_OK, 0));
    add_row(make_row(dqc_pkg::OP_POP_FRONT,  -32'sd1, 1'b1, 32'sd0, dqc_pkg::ST_EMPTY, 0));
    for (int i = 0; i < dqc_pkg::CAPACITY; i++) begin
      add_row(make_row((i % 2 == 0) ? dqc_pkg::OP_PUSH_FRONT : dqc_pkg::OP_PUSH_BACK,
                       (i % 4 == 0) ? 32'shaaaaaaaa :
                       (i % 4 == 1) ? 32'sh55555555 :
                       (i % 4 == 2) ? -32'sd1 : 32'(i),
                       1'b0, 32'sd0, dqc_pkg::ST_OK, 0));
    end
    add_row(make_row(dqc_pkg::OP_PUSH_BACK,  32'sh12345678, 1'b1, 32'sd0,
                     dqc_pkg::ST_FULL, dqc_pkg::CAPACITY));
    add_row(make_row(dqc_pkg::OP_PUSH_FRONT, 32'sh80000000, 1'b1, 32'sd0,
                     dqc_pkg::ST_FULL, dqc_pkg::CAPACITY));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      issue_op(directed_rows[ROW_W'(i)].op, directed_rows[ROW_W'(i)].val,
               directed_rows[ROW_W'(i)].typed, directed_rows[ROW_W'(i)].want);
    end

    burst_left = 0;
    push_bias  = 50;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 33; recv_idle_pct = 46; end
        1:       begin send_idle_pct = 46; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int n = 0; n < RANDOM_OPS / 3; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 2))
            0:       push_bias = 80;
            1:       push_bias = 20;
            default: push_bias = 50;
          endcase
        end
        burst_left--;
        if ($urandom_range(0, 99) < push_bias) begin
          op = ($urandom_range(0, 1) == 0) ? dqc_pkg::OP_PUSH_BACK : dqc_pkg::OP_PUSH_FRONT;
        end else begin
          op = ($urandom_range(0, 1) == 0) ? dqc_pkg::OP_POP_BACK : dqc_pkg::OP_POP_FRONT;
        end
        issue_op(op, pick_value(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (log_wr_ptr != log_rd_ptr) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result beats are taken in order and matched against the oldest prediction.
  always @(posedge clk) begin
    deque_result_t want;
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (!rst && out_valid && out_ready) begin
      if (log_wr_ptr == log_rd_ptr) begin
        $display("%0t: unexpected result beat: value %0d status %0d fill %0d",
                 $time, out_value, status, fill_count);
        failures++;
      end else begin
        want = result_log[log_rd_ptr];
        log_rd_ptr = log_rd_ptr + LOG_W'(1);
        if (out_value !== want.value) begin
          $display("%0t: out_value mismatch: expected %0d, actual %0d",
                   $time, want.value, out_value);
          failures++;
        end
        if (status !== want.stat) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.stat, status);
          failures++;
        end
        if (fill_count !== want.fill) begin
          $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                   $time, want.fill, fill_count);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
